/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk, disabled while rst_n is low.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same assertion with the default clock and reset names.
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_RST(lbl, clk_i, rst_ni, prop)

`endif

/* hw/rtl/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants of the checksum frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned FRAME_LEN = 13;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN + 1);

  localparam logic [7:0]       SYNC_BYTE  = 8'hA5;
  localparam logic [7:0]       LEN_BYTE   = 8'h08;
  localparam logic [IDX_W-1:0] SUM_INDEX  = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] DATA_FIRST = IDX_W'(4);

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_ARM  = 2'd2
  } func_e;

  typedef enum logic {
    REG_SLAVE_ADDR = 1'b0,
    REG_TIMEOUT    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        status;
    logic [7:0]  command;
    logic [63:0] payload;
  } result_t;

endpackage

/* hw/rtl/checksum_frame_receiver.sv */
// ----------------------------------------------------------------------------
// checksum_frame_receiver
// Checks a 13-byte reply frame with additive checksum and reports its data.
// ----------------------------------------------------------------------------
// One item (received byte, tick or arm) is taken per clock cycle while in_stall_o
// is low; its result, if any, shows at the output register in the cycle after the
// transfer when that register is free, otherwise it waits in the skid entry until
// the sink takes the earlier result. The per-byte compare, checksum add and timer
// compare are all combinational from the item ports into the state and result
// registers. An output register plus one skid entry separate the sink:
// in_stall_o rises only when both hold results the sink has not yet taken.
module checksum_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [7:0]  command_o,
  output logic [63:0] payload_o
);

  `include "assert_macros.svh"

  logic [7:0]                slave_addr_q;
  logic [15:0]               timeout_q;
  logic                      armed_q, armed_d;
  logic [cfr_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                exp_cmd_q, exp_cmd_d;
  logic [63:0]               pay_q, pay_d;
  logic [15:0]               ticks_q, ticks_d;

  logic             accept;
  logic             buf_full;
  logic             res_valid;
  cfr_pkg::result_t res;
  cfr_pkg::result_t out_data;
  logic             bad;

  assign accept = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
      timeout_q    <= 16'd2000;
    end else if (cfg_we_i) begin
      unique case (cfr_pkg::reg_idx_e'(cfg_idx_i))
        cfr_pkg::REG_SLAVE_ADDR: slave_addr_q <= cfg_wdata_i[7:0];
        cfr_pkg::REG_TIMEOUT:    timeout_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx_q)
      4'd0:    bad = (value_i != cfr_pkg::SYNC_BYTE);
      4'd1:    bad = (value_i != slave_addr_q);
      4'd2:    bad = (value_i != exp_cmd_q);
      4'd3:    bad = (value_i != cfr_pkg::LEN_BYTE);
      default: bad = (idx_q > cfr_pkg::SUM_INDEX) ||
                     ((idx_q == cfr_pkg::SUM_INDEX) && (value_i != sum_q));
    endcase
  end

  always_comb begin
    armed_d     = armed_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    exp_cmd_d   = exp_cmd_q;
    pay_d       = pay_q;
    ticks_d     = ticks_q;
    res_valid   = 1'b0;
    res.status  = 1'b0;
    res.command = exp_cmd_q;
    res.payload = pay_q;
    if (accept) begin
      case (cfr_pkg::func_e'(func_i))
        cfr_pkg::FUNC_ARM: begin
          armed_d   = 1'b1;
          exp_cmd_d = value_i;
          pay_d     = '0;
          ticks_d   = '0;
          idx_d     = '0;
          sum_d     = '0;
        end
        cfr_pkg::FUNC_TICK: begin
          if (armed_q) begin
            if (ticks_q != 16'hFFFF) begin
              ticks_d = ticks_q + 16'd1;
            end
            if (ticks_d > timeout_q) begin
              armed_d     = 1'b0;
              idx_d       = '0;
              sum_d       = '0;
              res_valid   = 1'b1;
              res.status  = 1'b1;
              res.payload = '0;
            end
          end
        end
        cfr_pkg::FUNC_BYTE: begin
          if (armed_q) begin
            if (bad) begin
              idx_d = '0;
              sum_d = '0;
            end else if (idx_q == cfr_pkg::SUM_INDEX) begin
              armed_d   = 1'b0;
              idx_d     = '0;
              sum_d     = '0;
              res_valid = 1'b1;
            end else begin
              if (idx_q >= cfr_pkg::DATA_FIRST) begin
                pay_d = {pay_q[55:0], value_i};
              end
              sum_d = sum_q + value_i;
              idx_d = idx_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      idx_q     <= '0;
      sum_q     <= '0;
      exp_cmd_q <= '0;
      pay_q     <= '0;
      ticks_q   <= '0;
    end else begin
      armed_q   <= armed_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      exp_cmd_q <= exp_cmd_d;
      pay_q     <= pay_d;
      ticks_q   <= ticks_d;
    end
  end

  cfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_data)
  );

  assign in_stall_o = buf_full;
  assign status_o   = out_data.status;
  assign command_o  = out_data.command;
  assign payload_o  = out_data.payload;

  `ASSERT_DEF(a_stall_needs_out, in_stall_o |-> out_valid_o)
  `ASSERT_DEF(a_res_only_armed, res_valid |-> armed_q)
  `ASSERT_DEF(a_idx_range, idx_q <= cfr_pkg::SUM_INDEX)
  `ASSERT_DEF(a_arm_restarts,
              (accept && func_i == cfr_pkg::FUNC_ARM) |=> (armed_q && idx_q == '0))
  `ASSERT_DEF(a_res_disarms, res_valid |=> !armed_q || $past(func_i) == cfr_pkg::FUNC_ARM)

endmodule

/* hw/rtl/cfr_out_buf.sv */
// ----------------------------------------------------------------------------
// cfr_out_buf
// Output register with one skid entry between the receiver and its sink.
// ----------------------------------------------------------------------------
module cfr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cfr_pkg::result_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cfr_pkg::result_t data_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  cfr_pkg::result_t out_data_q;
  cfr_pkg::result_t skid_data_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (push_i) begin
        out_data_q <= data_i;
      end
    end else if (push_i) begin
      skid_data_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for checksum_frame_receiver. Drives arm, byte and tick
// transfers with random gaps and output stalls, tracks the frame state in a
// local predictor and compares every reported frame or timeout with it.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         IDLE_PCT    = 16;
  localparam int         WDOG_LIMIT  = 3000;
  localparam int         RAND_ITEMS  = 1300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i      = '0;
  logic [7:0]  value_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic [7:0]  command_o;
  logic [63:0] payload_o;

  checksum_frame_receiver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .command_o   (command_o),
    .payload_o   (payload_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]                m_slave   = 8'd1;
  logic [15:0]               m_timeout = 16'd2000;
  logic                      m_armed   = 1'b0;
  logic [cfr_pkg::IDX_W-1:0] m_index   = '0;
  logic [7:0]                m_sum     = '0;
  logic [7:0]                m_cmd     = '0;
  logic [63:0]               m_payload = '0;
  logic [15:0]               m_elapsed = '0;

  cfr_pkg::result_t expected_replies[$];

  bit quiet       = 1'b0;
  int fail_count  = 0;
  int n_items     = 0;
  int n_frames    = 0;
  int n_timeouts  = 0;
  int n_writes    = 0;
  int wdog_cycles = 0;

  // Returns 1 when the item is not ignored by the receiver.
  function automatic bit track_frame(input logic [1:0] f, input logic [7:0] v);
    cfr_pkg::result_t r;
    logic             bad;
    if (f == cfr_pkg::FUNC_ARM) begin
      m_armed   = 1'b1;
      m_cmd     = v;
      m_payload = '0;
      m_elapsed = '0;
      m_index   = '0;
      m_sum     = '0;
      return 1'b1;
    end
    if (!m_armed || f == FUNC_UNUSED) return 1'b0;
    if (f == cfr_pkg::FUNC_TICK) begin
      if (m_elapsed != 16'hFFFF) m_elapsed++;
      if (m_elapsed > m_timeout) begin
        m_armed   = 1'b0;
        m_index   = '0;
        m_sum     = '0;
        r.status  = 1'b1;
        r.command = m_cmd;
        r.payload = '0;
        expected_replies.push_back(r);
        n_timeouts++;
      end
      return 1'b1;
    end
    case (m_index)
      0:                  bad = (v != cfr_pkg::SYNC_BYTE);
      1:                  bad = (v != m_slave);
      2:                  bad = (v != m_cmd);
      3:                  bad = (v != cfr_pkg::LEN_BYTE);
      cfr_pkg::SUM_INDEX: bad = (v != m_sum);
      default:            bad = (m_index > cfr_pkg::SUM_INDEX);
    endcase
    if (bad) begin
      m_index = '0;
      m_sum   = '0;
    end else if (m_index == cfr_pkg::SUM_INDEX) begin
      m_armed   = 1'b0;
      m_index   = '0;
      m_sum     = '0;
      r.status  = 1'b0;
      r.command = m_cmd;
      r.payload = m_payload;
      expected_replies.push_back(r);
      n_frames++;
    end else begin
      if (m_index >= cfr_pkg::DATA_FIRST) m_payload = {m_payload[55:0], v};
      m_sum   = m_sum + v;
      m_index = m_index + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_payload();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rand_cmd();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic send_item(input logic [1:0] f, input logic [7:0] v);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (track_frame(f, v)) n_items++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [63:0] data,
                            input int corrupt_at, input int tick_pct, input int n_bytes);
    logic [7:0] fr [13];
    logic [7:0] sum;
    fr[0] = cfr_pkg::SYNC_BYTE;
    fr[1] = m_slave;
    fr[2] = cmd;
    fr[3] = cfr_pkg::LEN_BYTE;
    for (int i = 0; i < 8; i++) fr[4+i] = data[63-8*i -: 8];
    sum = '0;
    for (int i = 0; i < 12; i++) sum = sum + fr[i];
    fr[12] = sum;
    if (corrupt_at >= 0) fr[corrupt_at] = fr[corrupt_at] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < tick_pct) send_item(cfr_pkg::FUNC_TICK, 8'($urandom_range(255)));
      send_item(cfr_pkg::FUNC_BYTE, fr[i]);
    end
  endtask

  task automatic wait_results_done(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Only while no transfer is in flight.
  task automatic write_reg(input cfr_pkg::reg_idx_e idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == cfr_pkg::REG_SLAVE_ADDR) m_slave = data[7:0];
    else m_timeout = data;
    n_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_idle_items();
    send_item(cfr_pkg::FUNC_TICK, 8'h00);
    send_item(cfr_pkg::FUNC_BYTE, 8'hFF);
    send_item(FUNC_UNUSED, 8'hFF);
    wait_results_done(4);
  endtask

  task automatic test_rearm_frame();
    send_item(cfr_pkg::FUNC_ARM, 8'h00);
    send_item(cfr_pkg::FUNC_BYTE, cfr_pkg::SYNC_BYTE);
    send_item(FUNC_UNUSED, 8'h00);
    send_item(cfr_pkg::FUNC_ARM, 8'hFF);
    send_frame(8'hFF, 64'h00FF_807F_01FE_55AA, -1, 0, cfr_pkg::FRAME_LEN);
    wait_results_done(4);
  endtask

  task automatic test_timeout_zero();
    write_reg(cfr_pkg::REG_TIMEOUT, 16'h0000);
    send_item(cfr_pkg::FUNC_ARM, 8'h3C);
    send_item(cfr_pkg::FUNC_TICK, 8'hFF);
    wait_results_done(4);
  endtask

  task automatic test_timeout_max();
    write_reg(cfr_pkg::REG_TIMEOUT, 16'hFFFF);
    write_reg(cfr_pkg::REG_SLAVE_ADDR, 16'hABFF);
    send_item(cfr_pkg::FUNC_ARM, 8'h5A);
    repeat (3) send_item(cfr_pkg::FUNC_TICK, 8'($urandom_range(255)));
    wait_results_done(4);
  endtask

  task automatic test_random_traffic();
    int          start;
    int          phase;
    int          r;
    logic [7:0]  cmd;
    logic [7:0]  slave;
    logic [15:0] tmo;
    logic [63:0] data;
    start = n_items;
    phase = 0;
    while (n_items < start + RAND_ITEMS) begin
      quiet = (phase == 2);
      case ($urandom_range(3))
        0:       slave = 8'h00;
        1:       slave = 8'hFF;
        default: slave = 8'($urandom_range(255));
      endcase
      write_reg(cfr_pkg::REG_SLAVE_ADDR, {8'($urandom_range(255)), slave});
      case ($urandom_range(5))
        0:       tmo = 16'h0000;
        1:       tmo = 16'hFFFF;
        2, 3:    tmo = 16'($urandom_range(1, 30));
        default: tmo = 16'($urandom_range(31, 400));
      endcase
      write_reg(cfr_pkg::REG_TIMEOUT, tmo);
      repeat ($urandom_range(4, 12)) begin
        cmd  = rand_cmd();
        data = rand_payload();
        r    = $urandom_range(99);
        if (r < 55) begin
          send_item(cfr_pkg::FUNC_ARM, cmd);
          send_frame(cmd, data, -1, 8, cfr_pkg::FRAME_LEN);
        end else if (r < 72) begin
          // broken frame, sometimes followed by a clean retry without re-arming
          send_item(cfr_pkg::FUNC_ARM, cmd);
          send_frame(cmd, data, $urandom_range(cfr_pkg::FRAME_LEN - 1), 8,
                     cfr_pkg::FRAME_LEN);
          if ($urandom_range(1))
            send_frame(cmd, rand_payload(), -1, 8, cfr_pkg::FRAME_LEN);
        end else if (r < 84) begin
          repeat ($urandom_range(1, 6))
            send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        end else if (r < 92) begin
          send_item(cfr_pkg::FUNC_ARM, cmd);
          repeat ($urandom_range(1, 40))
            send_item(cfr_pkg::FUNC_TICK, 8'($urandom_range(255)));
        end else begin
          send_item(cfr_pkg::FUNC_ARM, cmd);
          send_frame(cmd, data, -1, 0, $urandom_range(1, cfr_pkg::FRAME_LEN - 1));
          cmd = rand_cmd();
          send_item(cfr_pkg::FUNC_ARM, cmd);
          send_frame(cmd, rand_payload(), -1, 8, cfr_pkg::FRAME_LEN);
        end
      end
      wait_results_done(4);
      phase++;
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin : check_blk
    cfr_pkg::result_t exp_r;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result: status %0d command %0h payload %h",
               status_o, command_o, payload_o);
        fail_count++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          fail_count++;
        end
        if (command_o !== exp_r.command) begin
          $error("command: expected %0h, got %0h", exp_r.command, command_o);
          fail_count++;
        end
        if (payload_o !== exp_r.payload) begin
          $error("payload: expected %h, got %h", exp_r.payload, payload_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        wdog_cycles <= 0;
      else
        wdog_cycles <= wdog_cycles + 1;
      if (wdog_cycles >= WDOG_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 wdog_cycles, expected_replies.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_items();
    test_rearm_frame();
    test_timeout_zero();
    test_timeout_max();
    test_random_traffic();
    wait_results_done(8);
    $display("Covered %0d effective transfers and %0d register writes;", n_items, n_writes);
    $display("checked %0d complete frames and %0d timeouts.", n_frames, n_timeouts);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
